FILE: design/u8ld_pkg.sv
// ----------------------------------------------------------------------------
// u8ld_pkg - shared types and constants for the lenient UTF-8 decoder
// Holds the offset widths, the run descriptor passed from front to back end,
// and the sizing of the run queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8ld_pkg;

  // Width of the internal byte position counter (saturating).
  localparam int unsigned OffsetWidth = 32;
  // Width of the start offset as seen on the result port.
  localparam int unsigned OutOffWidth = 32;
  localparam int unsigned CodeWidth   = 21;
  localparam int unsigned LenWidth    = 3;

  // Run queue sizing.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [LenWidth-1:0] LenOne   = 3'd1;
  localparam logic [LenWidth-1:0] LenTwo   = 3'd2;
  localparam logic [LenWidth-1:0] LenThree = 3'd3;
  localparam logic [LenWidth-1:0] LenFour  = 3'd4;

  typedef logic [OffsetWidth-1:0] offset_t;

  // Everything one input byte causes: a run of single bytes flushed from a
  // broken or unfinished sequence (consecutive offsets from flush_start),
  // followed by at most one further result.
  typedef struct packed {
    logic [1:0]           flush_cnt;
    logic [2:0][7:0]      flush_byte;
    offset_t              flush_start;
    logic                 tail_vld;
    logic [CodeWidth-1:0] tail_code;
    offset_t              tail_start;
    logic [LenWidth-1:0]  tail_len;
  } run_desc_t;

endpackage

FILE: design/u8ld_front.sv
// ----------------------------------------------------------------------------
// u8ld_front - byte classifier and sequence tracker
// Takes one byte per transfer, tracks the open multi-byte sequence and the
// byte position, and writes one run descriptor per byte that yields results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8ld_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [7:0]          text_byte_i,
  input  wire logic                end_of_text_i,
  input  wire logic                queue_full_i,
  output      logic                in_stall_o,
  output      logic                push_o,
  output      u8ld_pkg::run_desc_t desc_o
);

  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Val  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Val  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Val  = 8'hF0;
  localparam logic [7:0] Pay2Mask  = 8'h1F;
  localparam logic [7:0] Pay3Mask  = 8'h0F;
  localparam logic [7:0] Pay4Mask  = 8'h07;

  logic [7:0]                         lead_q, lead_d;
  logic [u8ld_pkg::LenWidth-1:0]      exp_q, exp_d;
  logic [1:0]                         br_q, br_d;
  logic [u8ld_pkg::CodeWidth-1:0]     partial_q, partial_d;
  logic [7:0]                         hc0_q, hc0_d, hc1_q, hc1_d;
  u8ld_pkg::offset_t                  pos_q, pos_d;

  logic                               accept;
  logic                               is_cont;
  logic                               seq_open;
  logic                               complete;
  logic [2:0]                         br_inc;
  u8ld_pkg::offset_t                  pos_inc;
  logic [u8ld_pkg::LenWidth-1:0]      fresh_len;
  logic [u8ld_pkg::CodeWidth-1:0]     fresh_code;
  logic [u8ld_pkg::CodeWidth-1:0]     partial_new;
  u8ld_pkg::run_desc_t                desc;

  assign accept     = in_valid_i && !queue_full_i;
  assign in_stall_o = queue_full_i;

  // Lead byte classification
  always_comb begin
    fresh_len  = u8ld_pkg::LenOne;
    fresh_code = u8ld_pkg::CodeWidth'(text_byte_i);
    if ((text_byte_i & Lead2Mask) == Lead2Val) begin
      fresh_len  = u8ld_pkg::LenTwo;
      fresh_code = u8ld_pkg::CodeWidth'(text_byte_i & Pay2Mask);
    end else if ((text_byte_i & Lead3Mask) == Lead3Val) begin
      fresh_len  = u8ld_pkg::LenThree;
      fresh_code = u8ld_pkg::CodeWidth'(text_byte_i & Pay3Mask);
    end else if ((text_byte_i & Lead4Mask) == Lead4Val) begin
      fresh_len  = u8ld_pkg::LenFour;
      fresh_code = u8ld_pkg::CodeWidth'(text_byte_i & Pay4Mask);
    end
  end

  assign is_cont     = (text_byte_i[7:6] == 2'b10);
  assign seq_open    = (exp_q != '0);
  assign br_inc      = {1'b0, br_q} + 3'd1;
  assign complete    = (br_inc >= exp_q);
  assign pos_inc     = pos_q + u8ld_pkg::OffsetWidth'(1);
  assign partial_new = {partial_q[u8ld_pkg::CodeWidth-7:0], text_byte_i[5:0]};

  always_comb begin
    lead_d    = lead_q;
    exp_d     = exp_q;
    br_d      = br_q;
    partial_d = partial_q;
    hc0_d     = hc0_q;
    hc1_d     = hc1_q;

    desc             = '0;
    desc.flush_byte  = {hc1_q, hc0_q, lead_q};
    desc.flush_start = pos_q - u8ld_pkg::OffsetWidth'(br_q);

    if (seq_open && is_cont) begin
      if (complete) begin
        desc.tail_vld   = 1'b1;
        desc.tail_code  = partial_new;
        desc.tail_start = pos_q - u8ld_pkg::OffsetWidth'(br_q);
        desc.tail_len   = exp_q;
        exp_d     = '0;
        br_d      = '0;
        partial_d = '0;
      end else begin
        partial_d = partial_new;
        br_d      = br_inc[1:0];
        if (br_q == 2'd1) begin
          hc0_d = text_byte_i;
        end else begin
          hc1_d = text_byte_i;
        end
        // end of text with the sequence still short: give its bytes singly
        if (end_of_text_i) begin
          desc.flush_cnt   = br_inc[1:0];
          desc.flush_byte  = {(br_q == 2'd2) ? text_byte_i : hc1_q,
                              (br_q == 2'd1) ? text_byte_i : hc0_q,
                              lead_q};
          desc.flush_start = pos_inc - u8ld_pkg::OffsetWidth'(br_inc);
          exp_d     = '0;
          br_d      = '0;
          partial_d = '0;
        end
      end
    end else begin
      // broken sequence: held bytes go out singly, then this byte afresh
      if (seq_open) begin
        desc.flush_cnt = br_q;
        exp_d     = '0;
        br_d      = '0;
        partial_d = '0;
      end
      // a lead at end of text is flushed straight away, same as a single byte
      if (fresh_len == u8ld_pkg::LenOne || end_of_text_i) begin
        desc.tail_vld   = 1'b1;
        desc.tail_code  = u8ld_pkg::CodeWidth'(text_byte_i);
        desc.tail_start = pos_q;
        desc.tail_len   = u8ld_pkg::LenOne;
      end else begin
        lead_d    = text_byte_i;
        exp_d     = fresh_len;
        br_d      = 2'd1;
        partial_d = fresh_code;
      end
    end

    if (end_of_text_i) begin
      pos_d = '0;
    end else if (pos_q != '1) begin
      pos_d = pos_inc;
    end else begin
      pos_d = pos_q;
    end
  end

  assign push_o = accept && (desc.flush_cnt != 2'd0 || desc.tail_vld);
  assign desc_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      exp_q     <= '0;
      br_q      <= '0;
      partial_q <= '0;
      pos_q     <= '0;
    end else if (accept) begin
      lead_q    <= lead_d;
      exp_q     <= exp_d;
      br_q      <= br_d;
      partial_q <= partial_d;
      pos_q     <= pos_d;
    end
  end

  // held continuation bytes: only read after being written
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hc0_q <= hc0_d;
      hc1_q <= hc1_d;
    end
  end

`ifndef ASSERT_OFF
  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_open |-> (br_q != 2'd0) && ({1'b0, br_q} < exp_q))
    else $error("open sequence with bad received count");

  a_closed_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seq_open |-> (br_q == 2'd0) && (partial_q == '0))
    else $error("closed sequence left state behind");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_text_i |=> !seq_open && (pos_q == '0))
    else $error("end of text did not close the sequence");
`endif

endmodule

`default_nettype wire

FILE: design/u8ld_queue.sv
// ----------------------------------------------------------------------------
// u8ld_queue - run descriptor queue
// Small FIFO between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8ld_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire u8ld_pkg::run_desc_t push_desc_i,
  input  wire logic                pop_i,
  output      logic                full_o,
  output      logic                valid_o,
  output      u8ld_pkg::run_desc_t head_o
);

  u8ld_pkg::run_desc_t                 entry_q [u8ld_pkg::QueueDepth];
  logic [u8ld_pkg::QueuePtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [u8ld_pkg::QueuePtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [u8ld_pkg::QueueCntW-1:0]      cnt_q, cnt_d;

  localparam logic [u8ld_pkg::QueuePtrW-1:0] LastPtr =
    u8ld_pkg::QueuePtrW'(u8ld_pkg::QueueDepth - 1);
  localparam logic [u8ld_pkg::QueuePtrW-1:0] OnePtr = u8ld_pkg::QueuePtrW'(1);
  localparam logic [u8ld_pkg::QueueCntW-1:0] FullCnt =
    u8ld_pkg::QueueCntW'(u8ld_pkg::QueueDepth);
  localparam logic [u8ld_pkg::QueueCntW-1:0] OneCnt = u8ld_pkg::QueueCntW'(1);

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + OnePtr;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + OnePtr;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + OneCnt;
      2'b01:   cnt_d = cnt_q - OneCnt;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/u8ld_back.sv
// ----------------------------------------------------------------------------
// u8ld_back - result sequencer
// Walks the queue head one result per cycle, while the output is not stalled,
// into the output register and releases the descriptor with its last result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8ld_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 q_valid_i,
  input  wire u8ld_pkg::run_desc_t                  q_head_i,
  output      logic                                 q_pop_o,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      logic [u8ld_pkg::CodeWidth-1:0]       code_point_o,
  output      logic [u8ld_pkg::OutOffWidth-1:0]     start_offset_o,
  output      logic [u8ld_pkg::LenWidth-1:0]        byte_length_o,
  output      logic                                 last_of_run_o
);

  logic [1:0]                         k_q, k_d;
  logic                               out_valid_q, out_valid_d;
  logic [u8ld_pkg::CodeWidth-1:0]     code_q;
  logic [u8ld_pkg::OutOffWidth-1:0]   start_q;
  logic [u8ld_pkg::LenWidth-1:0]      len_q;
  logic                               last_q;

  logic [2:0]                         n_items;
  logic                               is_last;
  logic                               in_flush;
  logic                               load;
  logic [7:0]                         flush_byte;
  logic [u8ld_pkg::CodeWidth-1:0]     cur_code;
  u8ld_pkg::offset_t                  cur_start;
  logic [u8ld_pkg::LenWidth-1:0]      cur_len;

  assign n_items  = {1'b0, q_head_i.flush_cnt} + {2'b00, q_head_i.tail_vld};
  assign is_last  = ({1'b0, k_q} == n_items - 3'd1);
  assign in_flush = (k_q < q_head_i.flush_cnt);

  always_comb begin
    case (k_q)
      2'd0:    flush_byte = q_head_i.flush_byte[0];
      2'd1:    flush_byte = q_head_i.flush_byte[1];
      default: flush_byte = q_head_i.flush_byte[2];
    endcase
    if (in_flush) begin
      cur_code  = u8ld_pkg::CodeWidth'(flush_byte);
      cur_start = q_head_i.flush_start + u8ld_pkg::OffsetWidth'(k_q);
      cur_len   = u8ld_pkg::LenOne;
    end else begin
      cur_code  = q_head_i.tail_code;
      cur_start = q_head_i.tail_start;
      cur_len   = q_head_i.tail_len;
    end
  end

  // output slot is free when empty or being taken this cycle
  assign load    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = load && is_last;

  always_comb begin
    k_d = k_q;
    if (load) begin
      k_d = is_last ? 2'd0 : k_q + 2'd1;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q  <= cur_code;
      start_q <= u8ld_pkg::OutOffWidth'(cur_start);
      len_q   <= cur_len;
      last_q  <= is_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_point_o   = code_q;
  assign start_offset_o = start_q;
  assign byte_length_o  = len_q;
  assign last_of_run_o  = last_q;

`ifndef ASSERT_OFF
  a_multi_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (len_q != u8ld_pkg::LenOne) |-> last_q)
    else $error("multi-byte result not last of its run");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (len_q != 3'd0) && (len_q <= u8ld_pkg::LenFour))
    else $error("result length out of range");

  a_mid_run_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != 2'd0) |-> q_valid_i && (n_items > {1'b0, k_q}))
    else $error("sequencer mid-run without a matching descriptor");
`endif

endmodule

`default_nettype wire

FILE: design/utf8_lenient_decoder.sv
// ----------------------------------------------------------------------------
// utf8_lenient_decoder - lenient UTF-8 byte stream decoder
// Decodes one byte per transfer into code points with start offset and byte
// length; malformed or unfinished sequences come out as single bytes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | sink      | in_valid_i / in_stall_o   | text_byte_i, end_of_text_i
//  out     | source    | out_valid_o / out_stall_i | code_point_o, start_offset_o,
//          |           |                           | byte_length_o, last_of_run_o
//
//  - One byte is taken per cycle while in_stall_o is low. Its descriptor is
//    written into the queue at the transfer; the back end then loads its
//    results into the output register, from which each is transferred.
//  - Each byte gives zero to four results; an unstalled sequencer emits one
//    result per cycle, so the input keeps one byte per cycle while bytes
//    average at most one result each, until a flushed burst fills the queue.
//  - in_stall_o is high while the two-entry descriptor queue is full; it does
//    not depend on out_stall_i within the same cycle.
//  - Reset (rst_ni low, asynchronous) closes any open sequence, clears the
//    byte position and empties the queue and output register.
//
// The front end classifies each byte and updates the sequence state; it
// writes a run descriptor (singly flushed bytes, then at most one further
// result) to the queue. The back end walks that descriptor out one result
// per cycle. An output stall holds the back end only; the front keeps going
// until the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_lenient_decoder (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [7:0]                       text_byte_i,
  input  wire logic                             end_of_text_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [u8ld_pkg::CodeWidth-1:0]   code_point_o,
  output      logic [u8ld_pkg::OutOffWidth-1:0] start_offset_o,
  output      logic [u8ld_pkg::LenWidth-1:0]    byte_length_o,
  output      logic                             last_of_run_o
);

  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_valid;
  u8ld_pkg::run_desc_t push_desc;
  u8ld_pkg::run_desc_t q_head;

  // Byte classification and sequence tracking
  u8ld_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .queue_full_i  (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .desc_o        (push_desc)
  );

  // Decouples the two halves so an output stall does not stop byte transfers until the queue fills
  u8ld_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // One result per cycle into the output register while the output is not stalled
  u8ld_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_head_i       (q_head),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_point_o   (code_point_o),
    .start_offset_o (start_offset_o),
    .byte_length_o  (byte_length_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

FILE: sim/tb_utf8_lenient_decoder.sv
// ----------------------------------------------------------------------------
// tb_utf8_lenient_decoder - self-checking bench for the lenient UTF-8 decoder
// Drives a byte stream of good, broken and noisy sequences with random idling
// on both channels; a scoreboard predicts every character and checks each
// result transfer, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_lenient_decoder;

  // Bytes in the random part, after the directed opening.
  localparam int unsigned RandomBytes = 448;
  // Cycles with no transfer on either channel before the run is abandoned.
  localparam int unsigned StuckLimit  = 1000;
  // Settling time after the last result.
  localparam int unsigned DrainCycles = 8;

  // One predicted character as it should appear on the result channel.
  typedef struct packed {
    logic [u8ld_pkg::CodeWidth-1:0]   code;
    logic [u8ld_pkg::OutOffWidth-1:0] start;
    logic [u8ld_pkg::LenWidth-1:0]    len;
    logic                             last;
  } char_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the decoder state, turns each byte
  // transfer into the characters it causes and checks results against them.
  // --------------------------------------------------------------------------
  class utf8_char_board;
    logic [7:0]                     lead;      // lead byte of the open sequence
    logic [u8ld_pkg::LenWidth-1:0]  want_len;  // 0 while no sequence is open
    logic [1:0]                     got;       // bytes of the open sequence so far
    logic [u8ld_pkg::CodeWidth-1:0] acc;       // code point built up so far
    logic [7:0]                     conts [2]; // continuations held for a flush
    u8ld_pkg::offset_t              pos;       // offset of the next byte, saturating
    char_t                          chars_due [$];
    char_t                          run [$];
    int unsigned                    fails;

    function new();
      lead     = '0;
      want_len = '0;
      got      = '0;
      acc      = '0;
      conts    = '{8'h00, 8'h00};
      pos      = '0;
      fails    = 0;
    endfunction

    function void add(logic [u8ld_pkg::CodeWidth-1:0] code, u8ld_pkg::offset_t start,
                      logic [u8ld_pkg::LenWidth-1:0] len);
      char_t c;
      c.code  = code;
      c.start = start[u8ld_pkg::OutOffWidth-1:0];
      c.len   = len;
      c.last  = 1'b0;
      run = {run, c};
    endfunction

    function void close_seq();
      want_len = '0;
      got      = '0;
      acc      = '0;
    endfunction

    // Give the open sequence back as single bytes; 'at' is one past its end.
    function void spill(u8ld_pkg::offset_t at);
      u8ld_pkg::offset_t first;
      first = at - u8ld_pkg::offset_t'(got);
      add(u8ld_pkg::CodeWidth'(lead), first, u8ld_pkg::LenOne);
      for (int k = 1; k < int'(got) && k < 3; k++)
        add(u8ld_pkg::CodeWidth'(conts[k-1]), first + u8ld_pkg::offset_t'(k),
            u8ld_pkg::LenOne);
      close_seq();
    endfunction

    // A byte seen with no sequence open: a lead opens one, anything else
    // stands for itself.
    function void open_or_pass(logic [7:0] b, u8ld_pkg::offset_t at);
      casez (b)
        8'b110?????: begin
          want_len = u8ld_pkg::LenTwo;
          acc      = u8ld_pkg::CodeWidth'(b[4:0]);
        end
        8'b1110????: begin
          want_len = u8ld_pkg::LenThree;
          acc      = u8ld_pkg::CodeWidth'(b[3:0]);
        end
        8'b11110???: begin
          want_len = u8ld_pkg::LenFour;
          acc      = u8ld_pkg::CodeWidth'(b[2:0]);
        end
        default: begin
          add(u8ld_pkg::CodeWidth'(b), at, u8ld_pkg::LenOne);
          return;
        end
      endcase
      lead = b;
      got  = 2'd1;
    endfunction

    function void take_byte(logic [7:0] b, logic eot);
      u8ld_pkg::offset_t at;
      at = pos;
      run.delete();
      if (want_len != '0) begin
        if (b[7:6] == 2'b10) begin
          acc = {acc[u8ld_pkg::CodeWidth-7:0], b[5:0]};
          if (int'(got) + 1 >= int'(want_len)) begin
            add(acc, at - u8ld_pkg::offset_t'(got), want_len);
            close_seq();
          end else begin
            // only reached with got at 1 or 2
            conts[got - 2'd1] = b;
            got = got + 2'd1;
          end
        end else begin
          spill(at);
          open_or_pass(b, at);
        end
      end else begin
        open_or_pass(b, at);
      end
      if (eot) begin
        if (want_len != '0) spill(at + u8ld_pkg::offset_t'(1));
        pos = '0;
      end else if (at != '1) begin
        pos = at + u8ld_pkg::offset_t'(1);
      end
      if (run.size() > 0) begin
        run[run.size()-1].last = 1'b1;
        chars_due = {chars_due, run};
      end
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] seen);
      fails++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
    endfunction

    function void match_char(logic [u8ld_pkg::CodeWidth-1:0] code,
                             logic [u8ld_pkg::OutOffWidth-1:0] start,
                             logic [u8ld_pkg::LenWidth-1:0] len, logic last);
      char_t want;
      if (chars_due.size() == 0) begin
        report("unexpected result, code point", '0, 32'(code));
        return;
      end
      want = chars_due.pop_front();
      if (want.code !== code)   report("code_point", 32'(want.code), 32'(code));
      if (want.start !== start) report("start_offset", 32'(want.start), 32'(start));
      if (want.len !== len)     report("byte_length", 32'(want.len), 32'(len));
      if (want.last !== last)   report("last_of_run", 32'(want.last), 32'(last));
    endfunction

    function int pending();
      return chars_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             in_valid_i    = 1'b0;
  logic                             in_stall_o;
  logic [7:0]                       text_byte_i   = 8'h00;
  logic                             end_of_text_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i   = 1'b0;
  logic [u8ld_pkg::CodeWidth-1:0]   code_point_o;
  logic [u8ld_pkg::OutOffWidth-1:0] start_offset_o;
  logic [u8ld_pkg::LenWidth-1:0]    byte_length_o;
  logic                             last_of_run_o;

  utf8_char_board board = new();
  int unsigned    sent = 0;           // byte transfers made by the sender
  int unsigned    stuck_cycles = 0;
  bit             quiet = 1'b0;       // no idling on either side while set

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  utf8_lenient_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_point_o   (code_point_o),
    .start_offset_o (start_offset_o),
    .byte_length_o  (byte_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Receiver: stalls about one cycle in six, never inside the quiet window.
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 16);
  end

  // Monitors. A byte's results reach the output register only after its byte
  // transfer, so the two checks never depend on each other within one edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      board.take_byte(text_byte_i, end_of_text_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      board.match_char(code_point_o, start_offset_o, byte_length_o, last_of_run_o);
  end

  // Watchdog: any transfer on either channel proves progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == StuckLimit) begin
      $display("%0t ns: no transfer for %0d cycles", $time, StuckLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // One byte transfer, with idle cycles in front of it at random. Valid is
  // only lowered for an idle cycle, so it never gets two updates in one step.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  function automatic logic rand_eot();
    return $urandom_range(0, 19) == 0;
  endfunction

  // Mostly well-formed characters with random payload bits; some truncated
  // sequences (the next lead or ASCII byte breaks them) and some raw noise.
  task automatic send_random_char();
    int unsigned kind;
    int unsigned n;
    int unsigned conts;
    logic [7:0]  lead;
    kind = $urandom_range(0, 99);
    n    = $urandom_range(1, 4);
    if (kind >= 85) begin
      send_byte(8'($urandom_range(0, 255)), rand_eot());
      return;
    end
    case (n)
      1:       lead = {1'b0, 7'($urandom)};
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    conts = n - 1;
    if (kind >= 70 && n > 1) conts = $urandom_range(0, n - 2);
    send_byte(lead, rand_eot());
    repeat (conts) send_byte({2'b10, 6'($urandom)}, rand_eot());
  endtask

  initial begin
    bit drained;
    int unsigned total;
    drained = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening
    send_byte(8'h00, 1'b0);                 // smallest single byte
    send_byte(8'h7F, 1'b0);                 // largest ASCII
    send_byte(8'hC3, 1'b0);                 // two-byte character
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);                 // three-byte character
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF7, 1'b0);                 // four bytes, all payload bits set
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h80, 1'b0);                 // stray continuation, taken singly
    send_byte(8'hFF, 1'b0);                 // never a lead
    send_byte(8'hE2, 1'b0);                 // bad continuation: lead, held byte,
    send_byte(8'h82, 1'b0);                 // then the ASCII byte afresh
    send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0);                 // three held bytes broken by a lead
    send_byte(8'h9F, 1'b0);                 // that is also the last byte: four
    send_byte(8'h98, 1'b0);                 // results from one transfer
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE2, 1'b0);                 // text ends on a continuation
    send_byte(8'h82, 1'b1);

    // Random part; a window in the middle runs with no idling at all, and the
    // sender waits once for the scoreboard to empty.
    total = sent + RandomBytes;
    while (sent < total) begin
      quiet <= (sent >= 200) && (sent < 300);
      if (!drained && sent >= 350) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (board.pending() != 0) @(posedge clk_i);
      end
      send_random_char();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (board.fails == 0 && board.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
